[rtl/swm_pkg.sv]
// Shared types and constants for the sliding window maximum block.
package swm_pkg;

  localparam int VALUE_W = 16;
  localparam int STAMP_W = 32;
  localparam int WIN_W   = 6;

  localparam logic [WIN_W-1:0] WIN_RESET = 6'd20;
  localparam logic [WIN_W-1:0] WIN_MIN   = 6'd1;

  typedef enum logic [1:0] {
    CMD_HOLD,
    CMD_INSERT,
    CMD_SHIFT
  } cmd_t;

  typedef struct packed {
    logic                      vld;
    logic signed [VALUE_W-1:0] value;
    logic [STAMP_W-1:0]        stamp;
  } entry_t;

  typedef struct packed {
    cmd_t                      cmd;
    logic signed [VALUE_W-1:0] value;
    logic [STAMP_W-1:0]        stamp;
  } cell_ctrl_t;

endpackage

[rtl/swm_cell.sv]
// One wedge cell: holds a (time, value) entry, keeps, takes a new sample or shifts.
module swm_cell (
  input  logic               clk,
  input  logic               rst,
  input  swm_pkg::cell_ctrl_t ctrl,
  input  logic               left_keep,
  input  swm_pkg::entry_t    right_e,
  output swm_pkg::entry_t    cur,
  output logic               keep
);

  logic                              vld_next;
  logic signed [swm_pkg::VALUE_W-1:0] value_next;
  logic [swm_pkg::STAMP_W-1:0]       stamp_next;

  // entry survives the back drop only if strictly greater than the new sample
  assign keep = cur.vld && ($signed(cur.value) > $signed(ctrl.value));

  always_comb begin
    vld_next   = cur.vld;
    value_next = cur.value;
    stamp_next = cur.stamp;
    case (ctrl.cmd)
      swm_pkg::CMD_INSERT: begin
        vld_next = keep || left_keep;
        if (!keep && left_keep) begin
          value_next = ctrl.value;
          stamp_next = ctrl.stamp;
        end
      end
      swm_pkg::CMD_SHIFT: begin
        vld_next   = right_e.vld;
        value_next = right_e.value;
        stamp_next = right_e.stamp;
      end
      default: begin
        vld_next = cur.vld;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    cur.value <= value_next;
    cur.stamp <= stamp_next;
    if (rst) begin
      cur.vld <= 1'b0;
    end else begin
      cur.vld <= vld_next;
    end
  end

endmodule

[rtl/sliding_window_maximum.sv]
// Top level: running maximum over a time window, built as a chain of wedge cells.
//
//   channel  signals                                 dir  transfer when
//   in       in_valid in_stall sample_value sample_time  in   in_valid & !in_stall
//   out      out_valid out_stall max_value            out  out_valid & !out_stall
//   cfg      cfg_valid cfg_ready window_length         in   cfg_valid & cfg_ready
//
// An item is inserted, then expired entries leave the front of the chain:
// the chain drops one front entry per cycle. The maximum then goes to the result register once it is free.
// Reset clears all cell valid bits and sets the window to 20.
// The result register lets the next item enter while a result waits on out_stall.
module sliding_window_maximum #(
  parameter int DEPTH = 32
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic signed [swm_pkg::VALUE_W-1:0] sample_value,
  input  logic [swm_pkg::STAMP_W-1:0]       sample_time,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic signed [swm_pkg::VALUE_W-1:0] max_value,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [swm_pkg::WIN_W-1:0]         window_length
);

  typedef enum logic [0:0] {
    ST_IDLE,
    ST_EXP
  } state_t;

  state_t                      state;
  logic [swm_pkg::WIN_W-1:0]   win;
  logic [swm_pkg::WIN_W-1:0]   cur_w;
  logic [swm_pkg::STAMP_W-1:0] cur_t;

  swm_pkg::entry_t     ent  [DEPTH];
  logic                keep [DEPTH];
  swm_pkg::entry_t     tail;
  swm_pkg::cell_ctrl_t ctrl;

  logic                        acc;
  logic                        expire;
  logic                        out_load;
  logic [swm_pkg::STAMP_W:0]   front_lim;

  assign cfg_ready = 1'b1;
  assign in_stall  = (state != ST_IDLE);
  assign acc       = in_valid && !in_stall;

  // front expires when stamp + w <= now, newest entry always stays
  assign front_lim = {1'b0, ent[0].stamp}
                   + {{(swm_pkg::STAMP_W + 1 - swm_pkg::WIN_W){1'b0}}, cur_w};
  assign expire    = (state == ST_EXP) && ent[1].vld && (front_lim <= {1'b0, cur_t});
  assign out_load  = (state == ST_EXP) && !expire && (!out_valid || !out_stall);

  always_comb begin
    ctrl.value = sample_value;
    ctrl.stamp = sample_time;
    ctrl.cmd   = swm_pkg::CMD_HOLD;
    tail.vld   = 1'b0;
    tail.value = sample_value;
    tail.stamp = sample_time;
    if (acc) begin
      // last cell kept means wedge full with all entries above the sample
      if (keep[DEPTH-1]) begin
        ctrl.cmd = swm_pkg::CMD_SHIFT;
        tail.vld = 1'b1;
      end else begin
        ctrl.cmd = swm_pkg::CMD_INSERT;
      end
    end else if (expire) begin
      ctrl.cmd = swm_pkg::CMD_SHIFT;
    end
  end

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic            lk;
    swm_pkg::entry_t re;
    if (i == 0) begin : g_first
      assign lk = 1'b1;
    end else begin : g_mid
      assign lk = keep[i-1];
    end
    if (i == DEPTH - 1) begin : g_last
      assign re = tail;
    end else begin : g_inner
      assign re = ent[i+1];
    end
    swm_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .ctrl      (ctrl),
      .left_keep (lk),
      .right_e   (re),
      .cur       (ent[i]),
      .keep      (keep[i])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      win       <= swm_pkg::WIN_RESET;
      out_valid <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        win <= window_length;
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (acc) begin
            state <= ST_EXP;
          end
        end
        ST_EXP: begin
          if (out_load) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      cur_t <= sample_time;
      cur_w <= (win == '0) ? swm_pkg::WIN_MIN : win;
    end
    if (out_load) begin
      max_value <= ent[0].value;
    end
  end

`ifndef SYNTH
  a_front_valid: assert property (@(posedge clk) disable iff (rst)
    (state == ST_EXP) |-> ent[0].vld)
    else $error("front cell empty after insert");

  a_accept_to_exp: assert property (@(posedge clk) disable iff (rst)
    acc |=> (state == ST_EXP))
    else $error("accepted item did not enter expiry");

  a_keep_newest: assert property (@(posedge clk) disable iff (rst)
    expire |=> ent[0].vld)
    else $error("expiry emptied the wedge");

  a_load_free: assert property (@(posedge clk) disable iff (rst)
    out_load |-> (!out_valid || !out_stall))
    else $error("result loaded over a pending one");

  a_no_shift_out_busy: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> (out_valid && $stable(max_value)))
    else $error("pending result disturbed");
`endif

endmodule

[sim/tb_sliding_window_maximum.sv]
// Testbench for sliding_window_maximum: directed table and random phases checked by a wedge model.
`timescale 1ns / 100ps

module tb_sliding_window_maximum;

  localparam int     DEPTH       = 32;
  localparam int     HOLD_CYCLES = 300;
  localparam int     DRAIN_WAIT  = 2 * DEPTH + 8;
  localparam int     PHASES      = 14;
  localparam int     PHASE_ITEMS = 80;
  localparam longint CYCLE_LIMIT = 1000000;

  typedef enum logic {ROW_SAMPLE, ROW_WINDOW} row_kind_t;

  typedef struct {
    row_kind_t                          kind;
    logic signed [swm_pkg::VALUE_W-1:0] value;
    logic [swm_pkg::STAMP_W-1:0]        stamp;  // window length on ROW_WINDOW rows
    bit                                 typed;
    logic signed [swm_pkg::VALUE_W-1:0] want;
  } row_t;

  typedef struct {
    logic signed [swm_pkg::VALUE_W-1:0] value;
    logic [swm_pkg::STAMP_W-1:0]        stamp;
  } wedge_entry_t;

  logic                               clk = 1'b0;
  logic                               rst = 1'b1;
  logic                               in_valid = 1'b0;
  logic                               in_stall;
  logic signed [swm_pkg::VALUE_W-1:0] sample_value = '0;
  logic [swm_pkg::STAMP_W-1:0]        sample_time = '0;
  logic                               out_valid;
  logic                               out_stall = 1'b0;
  logic signed [swm_pkg::VALUE_W-1:0] max_value;
  logic                               cfg_valid = 1'b0;
  logic                               cfg_ready;
  logic [swm_pkg::WIN_W-1:0]          window_length = '0;

  wedge_entry_t                       wedge[$];
  logic [swm_pkg::WIN_W-1:0]          window_cfg = swm_pkg::WIN_RESET;
  logic signed [swm_pkg::VALUE_W-1:0] max_expected[$];
  logic signed [swm_pkg::VALUE_W-1:0] max_want;
  row_t                               directed[$];
  int                                 errors = 0;
  longint                             cycles = 0;
  bit                                 hold_request = 1'b0;
  bit                                 no_gaps = 1'b0;

  always #1 clk = ~clk;

  sliding_window_maximum #(.DEPTH(DEPTH)) u_top (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .sample_value (sample_value),
    .sample_time  (sample_time),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .max_value    (max_value),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .window_length(window_length)
  );

  function automatic logic signed [swm_pkg::VALUE_W-1:0] window_max_step(
    input logic signed [swm_pkg::VALUE_W-1:0] value,
    input logic [swm_pkg::STAMP_W-1:0] stamp);
    longint       horizon;
    longint       span;
    longint       oldest;
    wedge_entry_t e;
    span = (window_cfg == '0) ? 1 : window_cfg;
    horizon = stamp;
    horizon = horizon - span;
    while (wedge.size() > 0 && wedge[$].value <= value) void'(wedge.pop_back());
    if (wedge.size() >= DEPTH) wedge.delete(0);
    e.value = value;
    e.stamp = stamp;
    wedge.insert(wedge.size(), e);
    while (wedge.size() > 1) begin
      oldest = wedge[0].stamp;
      if (oldest > horizon) break;
      wedge.delete(0);
    end
    return wedge[0].value;
  endfunction

  function automatic int idle_cycles();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 80);
  endfunction

  function automatic void add_row(input row_kind_t kind,
                                  input logic signed [swm_pkg::VALUE_W-1:0] value,
                                  input logic [swm_pkg::STAMP_W-1:0] stamp, input bit typed,
                                  input logic signed [swm_pkg::VALUE_W-1:0] want);
    row_t row;
    row.kind  = kind;
    row.value = value;
    row.stamp = stamp;
    row.typed = typed;
    row.want  = want;
    directed.insert(directed.size(), row);
  endfunction

  task automatic report_mismatch(input string what,
                                 input logic signed [swm_pkg::VALUE_W-1:0] got,
                                 input logic signed [swm_pkg::VALUE_W-1:0] want);
    errors++;
    if (errors <= 50) $display("mismatch at cycle %0d: %s got %0d expected %0d",
                               cycles, what, got, want);
  endtask

  task automatic send_sample(input logic signed [swm_pkg::VALUE_W-1:0] value,
                             input logic [swm_pkg::STAMP_W-1:0] stamp, input bit typed,
                             input logic signed [swm_pkg::VALUE_W-1:0] want);
    int                                 gap;
    logic signed [swm_pkg::VALUE_W-1:0] predicted;
    in_valid     <= 1'b1;
    sample_value <= value;
    sample_time  <= stamp;
    do @(posedge clk); while (in_stall);
    predicted = window_max_step(value, stamp);
    if (typed) predicted = want;
    max_expected.insert(max_expected.size(), predicted);
    gap = no_gaps ? 0 : idle_cycles();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // block must be idle: all results out and any trailing expiry finished
  task automatic write_window(input logic [swm_pkg::WIN_W-1:0] len);
    in_valid <= 1'b0;
    while (max_expected.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
    cfg_valid     <= 1'b1;
    window_length <= len;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid  <= 1'b0;
    window_cfg = len;
  endtask

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (max_expected.size() == 0) begin
        report_mismatch("unexpected max_value", max_value, '0);
      end else begin
        max_want = max_expected[0];
        max_expected.delete(0);
        if (max_value !== max_want) report_mismatch("max_value", max_value, max_want);
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  initial begin : stall_driver
    int n;
    wait (rst == 1'b0);
    forever begin
      @(posedge clk);
      if (hold_request) begin
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_request = 1'b0;
        out_stall <= 1'b0;
      end else if (!no_gaps) begin
        n = idle_cycles();
        if (n > 0) begin
          out_stall <= 1'b1;
          repeat (n) @(posedge clk);
          out_stall <= 1'b0;
        end
      end
    end
  end

  initial begin : stimulus
    int                                 phase;
    int                                 shape;
    int                                 r;
    int                                 lvl;
    logic [swm_pkg::WIN_W-1:0]          len;
    logic [swm_pkg::STAMP_W-1:0]        stamp;
    logic signed [swm_pkg::VALUE_W-1:0] value;

    // reset window, extremes, equal values, expiry right at the window edge
    add_row(ROW_SAMPLE, -16'sd5,     32'd0,  1, -16'sd5);
    add_row(ROW_SAMPLE, 16'sh7FFF,   32'd1,  1, 16'sh7FFF);
    add_row(ROW_SAMPLE, -16'sh8000,  32'd2,  1, 16'sh7FFF);
    add_row(ROW_SAMPLE, 16'sh7FFF,   32'd3,  1, 16'sh7FFF);
    add_row(ROW_SAMPLE, 16'sd100,    32'd23, 1, 16'sd100);
    add_row(ROW_SAMPLE, 16'sd99,     32'd24, 0, '0);
    add_row(ROW_SAMPLE, 16'sd50,     32'd43, 0, '0);
    // shortest window: output follows input
    add_row(ROW_WINDOW, '0, 32'(swm_pkg::WIN_MIN), 0, '0);
    add_row(ROW_SAMPLE, 16'sd7,      32'd44, 1, 16'sd7);
    add_row(ROW_SAMPLE, -16'sh8000,  32'd45, 1, -16'sh8000);
    // zero window acts as one
    add_row(ROW_WINDOW, '0, 32'd0, 0, '0);
    add_row(ROW_SAMPLE, -16'sd1,     32'd46, 1, -16'sd1);
    add_row(ROW_SAMPLE, -16'sd2,     32'd47, 1, -16'sd2);
    // window equal to the wedge depth, top of the time range, then time going backward
    add_row(ROW_WINDOW, '0, 32'd32, 0, '0);
    add_row(ROW_SAMPLE, 16'sh1234,   32'hFFFF_FFE0, 0, '0);
    add_row(ROW_SAMPLE, -16'sd300,   32'hFFFF_FFFF, 0, '0);
    add_row(ROW_SAMPLE, 16'sd10,     32'd5,  0, '0);
    add_row(ROW_SAMPLE, -16'sd20,    32'd5,  0, '0);
    add_row(ROW_SAMPLE, 16'sh7FFF,   32'd6,  0, '0);
    // window beyond wedge depth
    add_row(ROW_WINDOW, '0, 32'd63, 0, '0);
    add_row(ROW_SAMPLE, 16'sd1000,   32'd100, 0, '0);
    add_row(ROW_SAMPLE, 16'sd200,    32'd0,   0, '0);
    add_row(ROW_WINDOW, '0, 32'(swm_pkg::WIN_RESET), 0, '0);
    add_row(ROW_SAMPLE, 16'sd0,      32'd1000, 0, '0);
    add_row(ROW_SAMPLE, -16'sh8000,  32'h8000_0000, 0, '0);
    add_row(ROW_SAMPLE, 16'sh5555,   32'h5555_5555, 0, '0);
    add_row(ROW_SAMPLE, -16'sh5556,  32'hAAAA_AAAA, 0, '0);

    repeat (5) @(posedge clk);
    rst <= 1'b0;

    foreach (directed[i]) begin
      if (directed[i].kind == ROW_WINDOW)
        write_window(directed[i].stamp[swm_pkg::WIN_W-1:0]);
      else
        send_sample(directed[i].value, directed[i].stamp, directed[i].typed, directed[i].want);
    end

    for (phase = 0; phase < PHASES; phase++) begin
      shape = phase % 4;
      r = $urandom_range(0, 9);
      if (shape == 1)
        len = (r < 3) ? 6'd32 : (r < 6) ? 6'd63 : 6'($urandom_range(33, 62));
      else if (r == 0)
        len = '0;
      else if (r == 1)
        len = 6'd63;
      else if (r == 2)
        len = 6'($urandom_range(33, 62));
      else if (r == 3)
        len = swm_pkg::WIN_MIN;
      else if (r == 4)
        len = 6'd32;
      else
        len = 6'($urandom_range(2, 31));
      write_window(len);

      no_gaps = (phase % 5 == 2);
      if (phase == 6) hold_request = 1'b1;
      stamp = $urandom();
      lvl = int'($urandom_range(0, 65535)) - 32768;

      repeat (PHASE_ITEMS) begin
        r = $urandom_range(0, 99);
        if (r < 4) begin
          // noise: arbitrary value, time standing still or going back
          r = int'($urandom_range(0, 65535));
          value = r[swm_pkg::VALUE_W-1:0];
          stamp = stamp - $urandom_range(0, 40);
        end else begin
          if ($urandom_range(0, 99) < 70)
            stamp = stamp + 1;
          else
            stamp = stamp + $urandom_range(2, 2 * int'(len) + 2);
          case (shape)
            0: lvl = int'($urandom_range(0, 65535)) - 32768;
            1: begin
              lvl = lvl - int'($urandom_range(1, 60));
              if (lvl < -32768 || $urandom_range(0, 99) < 3)
                lvl = 32767 - int'($urandom_range(0, 1000));
            end
            2: lvl = int'($urandom_range(0, 7)) - 4;
            default: begin
              lvl = lvl + int'($urandom_range(0, 200)) - 40;
              if (lvl > 32767) lvl = -32768;
            end
          endcase
          value = lvl[swm_pkg::VALUE_W-1:0];
        end
        send_sample(value, stamp, 0, '0);
      end
    end
    no_gaps = 1'b0;

    in_valid <= 1'b0;
    while (max_expected.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
    if (errors == 0)
      $display("PASS");
    else
      $display("FAIL");
    $finish;
  end

endmodule

[sliding_window_maximum.f]
rtl/swm_pkg.sv
rtl/swm_cell.sv
rtl/sliding_window_maximum.sv
sim/tb_sliding_window_maximum.sv
